@@ hdl/atc_pkg.sv @@
// ----------------------------------------------------------------------------
// Attitude torque controller package
// Shared widths, codes and item types for the attitude torque controller.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int AXES        = 3;
    localparam int MAT_N       = AXES * AXES;
    localparam int WORD_W      = 32;
    localparam int LIM_W       = 31;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 32;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 96;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_LOAD    = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTROL_MODE    = 3'd0,
        REG_PROP_GAIN       = 3'd1,
        REG_DERIV_GAIN      = 3'd2,
        REG_INV_ANGLE_LIMIT = 3'd3,
        REG_INV_RATE_LIMIT  = 3'd4,
        REG_JET_FORCE       = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        MODE_PD          = 1'b0,
        MODE_PHASE_PLANE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        t_word             prop_gain;
        t_word             deriv_gain;
        logic [LIM_W-1:0]  inv_angle_limit;
        logic [LIM_W-1:0]  inv_rate_limit;
        logic [LIM_W-1:0]  jet_force;
    } t_cfg;

    typedef struct packed {
        t_opcode              op;
        t_word [AXES-1:0]     err;
        t_word [AXES-1:0]     rate;
        logic [IDX_W-1:0]     idx;
        t_word                value;
    } t_item;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

@@ hdl/attitude_torque_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Attitude torque controller
// Three-axis PD torque with inertia multiply, or phase-plane jet command.
// ----------------------------------------------------------------------------
// Usage: each slave transfer carries one item. tuser holds the opcode: a
// compute item (angle errors and rates in tdata) gives one master transfer
// with three torques; a load item writes one inertia matrix entry and gives
// no transfer. A load to an index above eight is discarded at the front end.
// Loads and computes take effect strictly in arrival order.
// Throughput: one item per cycle while the receiver does not stall; the
// four-stage back-end pipeline (gain multipliers, axis command, inertia
// multipliers, torque sum) sets the rate. The front end queues up to
// QUEUE_DEPTH items, so the slave side keeps accepting for a while after the
// master side stalls; when the receiver holds tready low while a torque waits
// at the output, the whole pipeline freezes and the queue then fills, after
// which s_axis_tready drops. Reset (synchronous, active low) empties the
// queue and pipeline, zeroes the inertia matrix and restores every register's
// reset value. Configuration is written through i_cfg_we while the block is
// idle.
// ----------------------------------------------------------------------------
module attitude_torque_controller_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: err_x, err_y, err_z, rate_x, rate_y, rate_z, inertia_index,
    //        inertia_value, then zero fill
    input  logic [atc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: opcode
    input  logic [0:0]                          s_axis_tuser,
    // Master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: torque_x, torque_y, torque_z
    output logic [atc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [atc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [atc_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int AXES = atc_pkg::AXES;

    atc_pkg::t_cfg                        r_cfg;
    atc_pkg::t_item                       in_item;
    atc_pkg::t_queue_head                 head;
    logic                                 pop;
    atc_pkg::t_word [AXES-1:0]            torque;

    // Unpack the slave payload into the item fields.
    always_comb begin
        in_item.op = atc_pkg::t_opcode'(s_axis_tuser[0]);
        for (int i = 0; i < AXES; i++) begin
            in_item.err[i]  = s_axis_tdata[i*32 +: 32];
            in_item.rate[i] = s_axis_tdata[(AXES+i)*32 +: 32];
        end
        in_item.idx   = s_axis_tdata[2*AXES*32 +: atc_pkg::IDX_W];
        in_item.value = s_axis_tdata[2*AXES*32 + atc_pkg::IDX_W +: 32];
    end

    // Configuration registers. The gains and limits are read live by the
    // back end; the user must write them only while idle, unchecked here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= atc_pkg::MODE_PD;
            r_cfg.prop_gain       <= '0;
            r_cfg.deriv_gain      <= '0;
            r_cfg.inv_angle_limit <= 31'd65536;
            r_cfg.inv_rate_limit  <= 31'd65536;
            r_cfg.jet_force       <= '0;
        end else if (i_cfg_we) begin
            unique case (atc_pkg::t_cfg_reg'(i_cfg_index))
                atc_pkg::REG_CONTROL_MODE: begin
                    r_cfg.mode <= atc_pkg::t_mode'(i_cfg_data[0]);
                end
                atc_pkg::REG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data;
                end
                atc_pkg::REG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data;
                end
                atc_pkg::REG_INV_ANGLE_LIMIT: begin
                    r_cfg.inv_angle_limit <= i_cfg_data[atc_pkg::LIM_W-1:0];
                end
                atc_pkg::REG_INV_RATE_LIMIT: begin
                    r_cfg.inv_rate_limit <= i_cfg_data[atc_pkg::LIM_W-1:0];
                end
                atc_pkg::REG_JET_FORCE: begin
                    r_cfg.jet_force <= i_cfg_data[atc_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    atc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    atc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_torque (torque)
    );

    assign m_axis_tdata = torque;

endmodule

@@ hdl/atc_front.sv @@
// ----------------------------------------------------------------------------
// Attitude torque controller front end
// Accepts input transfers, drops loads to entries that do not exist, and
// queues the rest in arrival order for the back end.
// ----------------------------------------------------------------------------
module atc_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  atc_pkg::t_item       i_item,
    output atc_pkg::t_queue_head o_head,
    input  logic                 i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    atc_pkg::t_item   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             drop;
    logic             push;
    logic             pop;

    // A load aimed past the last matrix entry has no effect at all.
    assign drop = (i_item.op == atc_pkg::OP_LOAD) &&
                  (i_item.idx >= atc_pkg::IDX_W'(atc_pkg::MAT_N));

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready && !drop;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

@@ hdl/atc_back.sv @@
// ----------------------------------------------------------------------------
// Attitude torque controller back end
// Four-stage pipeline: gain products, axis command, inertia products,
// torque sum. Inertia loads travel the pipe and write at the matrix stage.
// ----------------------------------------------------------------------------
module atc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atc_pkg::t_cfg                       i_cfg,
    input  atc_pkg::t_queue_head                i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output atc_pkg::t_word [atc_pkg::AXES-1:0]  o_torque
);

    localparam int AXES  = atc_pkg::AXES;
    localparam int MAT_N = atc_pkg::MAT_N;
    localparam logic signed [65:0] ONE_Q32 = 66'sh1_0000_0000;

    // Shift a wide Q32.32 value down to Q16.16 (floor) and saturate to 32 bits.
    function automatic atc_pkg::t_word sat_q16(input logic signed [65:0] v);
        logic fits;
        fits = (v[65:47] == {19{v[47]}});
        if (fits) begin
            return v[47:16];
        end else if (v[65]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    logic adv;
    logic is_pp;

    // Stage 1: gain products
    logic                       r_v1, r_load1;
    logic [atc_pkg::IDX_W-1:0]  r_idx1;
    atc_pkg::t_word             r_val1;
    logic signed [64:0]         r_pe [AXES];
    logic signed [64:0]         r_pr [AXES];
    logic signed [64:0]         n_pe [AXES];
    logic signed [64:0]         n_pr [AXES];
    logic signed [32:0]         b_err, b_rate;

    // Stage 2: axis command
    logic                       r_v2, r_load2;
    logic [atc_pkg::IDX_W-1:0]  r_idx2;
    atc_pkg::t_word             r_val2;
    atc_pkg::t_word             r_u  [AXES];
    atc_pkg::t_word             r_pp2 [AXES];
    atc_pkg::t_word             n_u  [AXES];
    atc_pkg::t_word             n_pp2 [AXES];

    // Inertia matrix, row-major
    atc_pkg::t_word             r_j [MAT_N];

    // Stage 3: inertia products
    logic                       r_v3;
    logic signed [63:0]         r_jp [MAT_N];
    logic signed [63:0]         n_jp [MAT_N];
    atc_pkg::t_word             r_pp3 [AXES];

    // Stage 4: output register
    logic                       r_v4;
    atc_pkg::t_word             r_t4 [AXES];
    atc_pkg::t_word             n_t4 [AXES];

    assign is_pp = (i_cfg.mode == atc_pkg::MODE_PHASE_PLANE);
    assign adv   = !r_v4 || i_ready;
    assign o_pop = adv && i_head.valid;

    // The same multipliers serve both modes; only the second operand changes.
    assign b_err  = is_pp ? {2'b00, i_cfg.inv_angle_limit}
                          : {i_cfg.prop_gain[31], i_cfg.prop_gain};
    assign b_rate = is_pp ? {2'b00, i_cfg.inv_rate_limit}
                          : {i_cfg.deriv_gain[31], i_cfg.deriv_gain};

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n_pe[i] = $signed(i_head.item.err[i]) * b_err;
            n_pr[i] = $signed(i_head.item.rate[i]) * b_rate;
        end
    end

    always_comb begin
        logic signed [65:0] pd_sum;
        logic signed [65:0] pp_sum;
        pd_sum = '0;
        pp_sum = '0;
        for (int i = 0; i < AXES; i++) begin
            pd_sum = 66'sd0 - {r_pe[i][64], r_pe[i]} - {r_pr[i][64], r_pr[i]};
            pp_sum = {r_pe[i][64], r_pe[i]} + {r_pr[i][64], r_pr[i]};
            n_u[i] = sat_q16(pd_sum);
            if (pp_sum > ONE_Q32) begin
                n_pp2[i] = 32'(-$signed({1'b0, i_cfg.jet_force}));
            end else if (pp_sum < -ONE_Q32) begin
                n_pp2[i] = $signed({1'b0, i_cfg.jet_force});
            end else begin
                n_pp2[i] = '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                n_jp[i*AXES+j] = $signed(r_j[i*AXES+j]) * $signed(r_u[j]);
            end
        end
    end

    always_comb begin
        logic signed [65:0] acc;
        acc = '0;
        for (int i = 0; i < AXES; i++) begin
            acc = {{2{r_jp[i*AXES][63]}},   r_jp[i*AXES]}
                + {{2{r_jp[i*AXES+1][63]}}, r_jp[i*AXES+1]}
                + {{2{r_jp[i*AXES+2][63]}}, r_jp[i*AXES+2]};
            n_t4[i] = is_pp ? r_pp3[i] : sat_q16(acc);
        end
    end

    // Valid flags; a load leaves the pipe after its matrix write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_load1 <= 1'b0;
            r_v2    <= 1'b0;
            r_load2 <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else if (adv) begin
            r_v1    <= i_head.valid;
            r_load1 <= i_head.valid && (i_head.item.op == atc_pkg::OP_LOAD);
            r_v2    <= r_v1;
            r_load2 <= r_load1;
            r_v3    <= r_v2 && !r_load2;
            r_v4    <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAT_N; k++) begin
                r_j[k] <= '0;
            end
        end else if (adv && r_v2 && r_load2) begin
            r_j[r_idx2] <= r_val2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_idx1 <= i_head.item.idx;
            r_val1 <= i_head.item.value;
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
            for (int i = 0; i < AXES; i++) begin
                r_pe[i]  <= n_pe[i];
                r_pr[i]  <= n_pr[i];
                r_u[i]   <= n_u[i];
                r_pp2[i] <= n_pp2[i];
                r_pp3[i] <= r_pp2[i];
                r_t4[i]  <= n_t4[i];
            end
            for (int k = 0; k < MAT_N; k++) begin
                r_jp[k] <= n_jp[k];
            end
        end
    end

    assign o_valid = r_v4;
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            o_torque[i] = r_t4[i];
        end
    end

endmodule

@@ tb/sv/tb_attitude_torque_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Attitude torque controller testbench
// Drives control samples and inertia loads into the stream input, mirrors
// every register write and inertia load in a bit-exact torque predictor, and
// checks each torque transfer on the stream output against the oldest
// outstanding prediction. Runs through PD and phase-plane settings under
// several sender and receiver stall profiles, including a long receiver hold.
// ----------------------------------------------------------------------------
module tb_attitude_torque_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import atc_pkg::*;

    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    ITEMS_PER_SET = 80;
    localparam int    SETTLE_CYCLES = 16;
    localparam t_word WORD_MAX      = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN      = 32'sh8000_0000;

    typedef logic signed [67:0] t_wide;

    // ------------------------------------------------------------------------
    // Torque scoreboard. It holds its own copy of the registers and of the
    // inertia matrix, predicts the torque triple of every accepted compute
    // sample, and compares torque transfers in order of arrival.
    // ------------------------------------------------------------------------
    class torque_scoreboard;
        t_mode                  mode;
        t_word                  prop_gain;
        t_word                  deriv_gain;
        logic [LIM_W-1:0]       inv_angle_limit;
        logic [LIM_W-1:0]       inv_rate_limit;
        logic [LIM_W-1:0]       jet_force;
        t_word                  inertia [MAT_N];
        logic [OUT_TDATA_W-1:0] pending_torques [$];
        int                     errors;

        function new();
            mode            = MODE_PD;
            prop_gain       = '0;
            deriv_gain      = '0;
            inv_angle_limit = 31'd65536;
            inv_rate_limit  = 31'd65536;
            jet_force       = '0;
            foreach (inertia[e]) inertia[e] = '0;
            errors          = 0;
        endfunction

        function t_wide wide(t_word w);
            return w;
        endfunction

        function t_word clip(t_wide v);
            if (v > t_wide'(WORD_MAX)) return WORD_MAX;
            if (v < t_wide'(WORD_MIN)) return WORD_MIN;
            return t_word'(v);
        endfunction

        function void apply_config(t_cfg_reg idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CONTROL_MODE:    mode = t_mode'(data[0]);
                REG_PROP_GAIN:       prop_gain = data;
                REG_DERIV_GAIN:      deriv_gain = data;
                REG_INV_ANGLE_LIMIT: inv_angle_limit = data[LIM_W-1:0];
                REG_INV_RATE_LIMIT:  inv_rate_limit = data[LIM_W-1:0];
                REG_JET_FORCE:       jet_force = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the three torques of one compute sample from its tdata.
        function logic [OUT_TDATA_W-1:0] predict_torque(logic [IN_TDATA_W-1:0] data);
            t_wide acc;
            t_wide lim_a;
            t_wide lim_r;
            t_wide one;
            t_word err;
            t_word rate;
            t_word u [AXES];
            t_word torque [AXES];
            one   = 68'sd4294967296;
            lim_a = $signed({37'd0, inv_angle_limit});
            lim_r = $signed({37'd0, inv_rate_limit});
            for (int a = 0; a < AXES; a++) begin
                err  = data[WORD_W*a +: WORD_W];
                rate = data[WORD_W*(AXES+a) +: WORD_W];
                if (mode == MODE_PHASE_PLANE) begin
                    // Switching line crossed: fire the jet against the error.
                    acc = wide(err) * lim_a + wide(rate) * lim_r;
                    if (acc > one) begin
                        torque[a] = -$signed({1'b0, jet_force});
                    end else if (acc < -one) begin
                        torque[a] = $signed({1'b0, jet_force});
                    end else begin
                        torque[a] = '0;
                    end
                end else begin
                    // Exact Q32.32 difference, floor shift back to Q16.16.
                    acc  = -(wide(prop_gain) * wide(err)) - wide(deriv_gain) * wide(rate);
                    u[a] = clip(acc >>> 16);
                end
            end
            if (mode == MODE_PD) begin
                for (int a = 0; a < AXES; a++) begin
                    acc = '0;
                    for (int b = 0; b < AXES; b++) begin
                        acc += wide(inertia[a*AXES+b]) * wide(u[b]);
                    end
                    torque[a] = clip(acc >>> 16);
                end
            end
            return {torque[2], torque[1], torque[0]};
        endfunction

        function void note_item(t_opcode op, logic [IN_TDATA_W-1:0] data);
            logic [IDX_W-1:0] idx;
            idx = data[2*AXES*WORD_W +: IDX_W];
            if (op == OP_LOAD) begin
                // Loads beyond the last entry are dropped by the block.
                if (idx < MAT_N) inertia[idx] = data[2*AXES*WORD_W+IDX_W +: WORD_W];
            end else begin
                pending_torques.push_back(predict_torque(data));
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            logic [OUT_TDATA_W-1:0] want;
            string                  axis_name [AXES];
            axis_name = '{"x", "y", "z"};
            if (pending_torques.size() == 0) begin
                report($sformatf("torque transfer %h with nothing expected", data));
                return;
            end
            want = pending_torques.pop_front();
            for (int a = 0; a < AXES; a++) begin
                if (data[WORD_W*a +: WORD_W] !== want[WORD_W*a +: WORD_W]) begin
                    report($sformatf("torque_%s got %0d expected %0d", axis_name[a],
                                     $signed(data[WORD_W*a +: WORD_W]),
                                     $signed(want[WORD_W*a +: WORD_W])));
                end
            end
        endtask

        function int pending_count();
            return pending_torques.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: err_x, err_y, err_z, rate_x, rate_y, rate_z, inertia_index,
    //        inertia_value, then zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: opcode
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: torque_x, torque_y, torque_z
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    t_cfg_reg               i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    torque_scoreboard sb;
    int               send_idle_pct;
    int               stall_pct;
    int               hold_cycles;
    int               cycle_count;

    attitude_torque_controller_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock period, 2 ns high and 2 ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit. It sits far above the slowest legal run, so reaching it
    // means the block has hung or lost transfers.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver. tready changes on the falling edge. A long hold, counted down
    // here, takes priority over the random stall rate; while it lasts the
    // pipeline freezes and the front-end queue fills up.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor. All three ports are sampled at the rising edge, where a
    // transfer or a register write takes effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.apply_config(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(t_opcode'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Values within +/-4.0 keep the PD chain mostly out of saturation and put
    // the phase-plane sum close to its switching lines.
    function automatic t_word moderate_word();
        return t_word'(int'($urandom_range(524288)) - 262144);
    endfunction

    function automatic t_word rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return t_word'($urandom);
        if (pick == 1) begin
            case ($urandom_range(4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return t_word'(0);
                3: return t_word'(-1);
                default: return t_word'(1);
            endcase
        end
        return moderate_word();
    endfunction

    function automatic t_item mk_compute(t_word ex, t_word ey, t_word ez,
                                         t_word rx, t_word ry, t_word rz);
        t_item it;
        it.op    = OP_COMPUTE;
        it.err   = {ez, ey, ex};
        it.rate  = {rz, ry, rx};
        it.idx   = IDX_W'($urandom_range(15));
        it.value = t_word'($urandom);
        return it;
    endfunction

    function automatic t_item mk_load(logic [IDX_W-1:0] idx, t_word value);
        t_item it;
        it       = mk_compute(rand_word(), rand_word(), rand_word(),
                              rand_word(), rand_word(), rand_word());
        it.op    = OP_LOAD;
        it.idx   = idx;
        it.value = value;
        return it;
    endfunction

    // Mostly compute samples; loads mostly hit valid entries, a few fall
    // beyond the matrix.
    function automatic t_item rand_item();
        t_item it;
        it = mk_compute(rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word(), rand_word());
        if ($urandom_range(99) < 20) begin
            it.op    = OP_LOAD;
            it.idx   = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(MAT_N - 1))
                                                 : IDX_W'($urandom_range(15));
            it.value = rand_word();
        end
        return it;
    endfunction

    // Offers one item on the slave side. Entered and left at a falling edge;
    // tvalid stays high across back-to-back transfers.
    task automatic offer(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.op;
        s_axis_tdata  = {4'b0, it.value, it.idx, it.rate[2], it.rate[1], it.rate[0],
                         it.err[2], it.err[1], it.err[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Writes all six registers. Unused upper bits carry random values, which
    // the block must ignore.
    task automatic program_regs(input t_cfg c);
        i_cfg_we    = 1'b1;
        i_cfg_index = REG_CONTROL_MODE;
        i_cfg_data  = {31'($urandom), c.mode};
        @(negedge i_clk);
        i_cfg_index = REG_PROP_GAIN;
        i_cfg_data  = c.prop_gain;
        @(negedge i_clk);
        i_cfg_index = REG_DERIV_GAIN;
        i_cfg_data  = c.deriv_gain;
        @(negedge i_clk);
        i_cfg_index = REG_INV_ANGLE_LIMIT;
        i_cfg_data  = {1'($urandom), c.inv_angle_limit};
        @(negedge i_clk);
        i_cfg_index = REG_INV_RATE_LIMIT;
        i_cfg_data  = {1'($urandom), c.inv_rate_limit};
        @(negedge i_clk);
        i_cfg_index = REG_JET_FORCE;
        i_cfg_data  = {1'($urandom), c.jet_force};
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Waits until every predicted torque has arrived, then lets trailing
    // loads, which give no transfer, drain through the queue and pipeline.
    task automatic settle();
        while (sb.pending_count() != 0) @(posedge i_clk);
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg  cfg;
        t_word j_init [MAT_N];
        j_init = '{32'sd65536, -32'sd32768, WORD_MAX,
                   32'sd0, 32'sd131072, 32'sd1,
                   WORD_MIN, 32'sd12345, 32'sd65536};

        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_COMPUTE;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_CONTROL_MODE;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        cycle_count   = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed PD part: gain 2.0 and -0.5, first a sample with the
        // inertia matrix still at its reset value of zero.
        cfg.mode            = MODE_PD;
        cfg.prop_gain       = 32'sd131072;
        cfg.deriv_gain      = -32'sd32768;
        cfg.inv_angle_limit = 31'd65536;
        cfg.inv_rate_limit  = 31'd65536;
        cfg.jet_force       = '0;
        program_regs(cfg);
        offer(mk_compute(32'sd65536, -32'sd131072, WORD_MAX, 32'sd0, 32'sd65536, WORD_MIN));
        for (int e = 0; e < MAT_N; e++) offer(mk_load(IDX_W'(e), j_init[e]));
        // Loads just past the matrix and at the top index are discarded.
        offer(mk_load(4'd9, WORD_MAX));
        offer(mk_load(4'd15, WORD_MIN));
        offer(mk_compute(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        offer(mk_compute(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        offer(mk_compute(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        offer(mk_compute(32'sd65536, -32'sd65536, 32'sd32768,
                         32'sd16384, -32'sd16384, 32'sd1));
        s_axis_tvalid = 1'b0;
        settle();

        // Directed phase-plane part: samples exactly on and just past the
        // switching lines, then the extremes.
        cfg.mode      = MODE_PHASE_PLANE;
        cfg.jet_force = 31'h7FFF_FFFF;
        program_regs(cfg);
        offer(mk_compute(32'sd65536, 32'sd65537, -32'sd65536, 32'sd0, 32'sd0, 32'sd0));
        offer(mk_compute(-32'sd65537, 32'sd0, 32'sd0, 32'sd0, 32'sd65537, -32'sd65537));
        offer(mk_compute(32'sd32768, 32'sd32768, -32'sd32768,
                         32'sd32769, 32'sd32767, -32'sd32769));
        offer(mk_compute(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX));
        s_axis_tvalid = 1'b0;
        settle();

        // A zero angle reciprocal removes the angle term entirely.
        cfg.inv_angle_limit = '0;
        program_regs(cfg);
        offer(mk_compute(WORD_MAX, WORD_MIN, 32'sd65537, 32'sd0, 32'sd65537, -32'sd65537));
        s_axis_tvalid = 1'b0;
        settle();

        // Random part: six register settings, alternating PD and phase-plane,
        // each under one stall profile.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg.mode            = MODE_PD;
                    cfg.prop_gain       = moderate_word();
                    cfg.deriv_gain      = moderate_word();
                    cfg.inv_angle_limit = 31'd65536;
                    cfg.inv_rate_limit  = 31'd65536;
                    cfg.jet_force       = 31'($urandom_range(1 << 20));
                end
                1: begin
                    cfg.mode            = MODE_PHASE_PLANE;
                    cfg.inv_angle_limit = 31'd65536;
                    cfg.inv_rate_limit  = 31'd32768;
                    cfg.jet_force       = 31'($urandom);
                end
                2: begin
                    cfg.mode       = MODE_PD;
                    cfg.prop_gain  = WORD_MAX;
                    cfg.deriv_gain = WORD_MIN;
                end
                3: begin
                    cfg.mode            = MODE_PHASE_PLANE;
                    cfg.inv_angle_limit = 31'h7FFF_FFFF;
                    cfg.inv_rate_limit  = '0;
                    cfg.jet_force       = 31'h7FFF_FFFF;
                end
                4: begin
                    cfg.mode       = MODE_PD;
                    cfg.prop_gain  = t_word'($urandom);
                    cfg.deriv_gain = '0;
                end
                default: begin
                    cfg.mode            = MODE_PHASE_PLANE;
                    cfg.inv_angle_limit = 31'($urandom_range(1 << 17, 1 << 14));
                    cfg.inv_rate_limit  = 31'($urandom_range(1 << 17, 1 << 14));
                    cfg.jet_force       = '0;
                end
            endcase
            program_regs(cfg);

            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // Receiver holds off long enough for the input side to
                    // back up while the sender keeps offering.
                    hold_cycles   = 80;
                end
                1: begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_SET; n++) offer(rand_item());
            s_axis_tvalid = 1'b0;
            send_idle_pct = 0;
            settle();
        end

        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/atc_pkg.sv
hdl/atc_front.sv
hdl/atc_back.sv
hdl/attitude_torque_controller_unit.sv
tb/sv/tb_attitude_torque_controller_unit.sv
